@@ rtl/ess_pkg.sv @@
// Shared types and constants for the event slit scan sampler.
// No dependencies; imported by every module of the block except ess_fifo.
package ess_pkg;

  // Field widths
  localparam int unsigned COORD_W  = 7;
  localparam int unsigned BIN_W    = 5;
  localparam int unsigned SLIT_W   = 2;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned CFG_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;

  // Counter store geometry: one bank of row bins per slit
  localparam int unsigned NUM_SLITS = 3;
  localparam int unsigned ROW_BINS  = 32;

  localparam logic [SLIT_W-1:0]  NO_SLIT   = 2'd3;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

  // Register reset values
  localparam logic [BIN_W-1:0]   SLIT0_BIN_RST  = 5'd5;
  localparam logic [BIN_W-1:0]   SLIT1_BIN_RST  = 5'd15;
  localparam logic [BIN_W-1:0]   SLIT2_BIN_RST  = 5'd25;
  localparam logic [COUNT_W-1:0] HIT_FLOOR_RST  = 8'd4;
  localparam logic [COUNT_W-1:0] BATCHES_RST    = 8'd16;

  // Register indexes on the write port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLIT0_BIN = 3'd0,
    REG_SLIT1_BIN = 3'd1,
    REG_SLIT2_BIN = 3'd2,
    REG_HIT_FLOOR = 3'd3,
    REG_BATCHES   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [BIN_W-1:0]   slit0_bin;
    logic [BIN_W-1:0]   slit1_bin;
    logic [BIN_W-1:0]   slit2_bin;
    logic [COUNT_W-1:0] hit_floor;
    logic [COUNT_W-1:0] batches;
  } cfg_t;

  // Classified event, front to back
  typedef struct packed {
    logic [SLIT_W-1:0]  slit;
    logic [COORD_W-1:0] row;
    logic               polarity;
  } event_t;

  // One emitted sample
  typedef struct packed {
    logic [SLIT_W-1:0]  slit_index;
    logic [COORD_W-1:0] row;
    logic               polarity;
    logic [COORD_W-1:0] weft;
    logic               above_floor;
  } sample_t;

endpackage

@@ rtl/ess_fifo.sv @@
// Small first-in first-out queue held in flops, registered storage.
// Generic; width and depth set by parameters. No package dependency.
module ess_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full     = (fill == CNT_W'(DEPTH));
  assign empty    = (fill == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = store[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/ess_front.sv @@
// Front end: takes events and decides which slit, if any, each one falls in.
// Depends on ess_pkg; writes classified events into the middle queue.
module ess_front (
  input  logic                         push,
  output logic                         full,
  input  logic [ess_pkg::COORD_W-1:0]  column,
  input  logic [ess_pkg::COORD_W-1:0]  row,
  input  logic                         polarity,
  input  ess_pkg::cfg_t                cfg,
  input  logic                         q_full,
  output logic                         q_push,
  output ess_pkg::event_t              q_data
);
  import ess_pkg::*;

  logic [BIN_W-1:0] col_bin;

  assign col_bin = column[COORD_W-1:2];

  // Lowest numbered slit wins when bins overlap
  always_comb begin
    priority if (col_bin == cfg.slit0_bin) begin
      q_data.slit = 2'd0;
    end else if (col_bin == cfg.slit1_bin) begin
      q_data.slit = 2'd1;
    end else if (col_bin == cfg.slit2_bin) begin
      q_data.slit = 2'd2;
    end else begin
      q_data.slit = NO_SLIT;
    end
    q_data.row      = row;
    q_data.polarity = polarity;
  end

  // Stall only when the middle queue has no room
  assign full   = q_full;
  assign q_push = push && !q_full;

endmodule

@@ rtl/ess_back.sv @@
// Back end: hit counters, candidate selection, batch and weft bookkeeping.
// Depends on ess_pkg; reads the middle queue and writes the result queue.
module ess_back #(
  parameter int unsigned EVENTS_PER_BATCH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  ess_pkg::cfg_t    cfg,
  input  logic             q_empty,
  input  ess_pkg::event_t  q_data,
  output logic             q_pop,
  input  logic             out_full,
  output logic             out_push,
  output ess_pkg::sample_t out_data
);
  import ess_pkg::*;

  localparam int unsigned POS_W = (EVENTS_PER_BATCH > 1) ? $clog2(EVENTS_PER_BATCH) : 1;
  localparam int unsigned ROW_BIN_W = $clog2(ROW_BINS);

  logic                 fire;
  logic                 hit;
  logic                 last_in_batch;
  logic                 advance;
  logic [ROW_BIN_W-1:0] row_bin;
  logic [COUNT_W-1:0]   bank_rd [NUM_SLITS];
  logic [COUNT_W-1:0]   cur_count;
  logic [COUNT_W-1:0]   new_count;
  logic                 flag;
  logic                 take;

  logic [POS_W-1:0]     position;
  logic [COUNT_W-1:0]   batch_tally;
  logic [COUNT_W-1:0]   batch_tally_next;
  logic [COORD_W-1:0]   weft;

  logic                 has_cand;
  logic [SLIT_W-1:0]    best_slit;
  logic [COORD_W-1:0]   best_row;
  logic                 best_pol;
  logic                 best_flag;

  logic                 has_cand_next;
  logic [SLIT_W-1:0]    best_slit_next;
  logic [COORD_W-1:0]   best_row_next;
  logic                 best_pol_next;
  logic                 best_flag_next;

  // One event per cycle whenever the result queue has room
  assign fire          = !q_empty && !out_full;
  assign q_pop         = fire;
  assign hit           = (q_data.slit != NO_SLIT);
  assign row_bin       = q_data.row[COORD_W-1:2];
  assign last_in_batch = (position == POS_W'(EVENTS_PER_BATCH - 1));
  assign out_push      = fire && last_in_batch;

  // Counter banks in flops, one per slit, flash cleared on a column advance
  for (genvar s = 0; s < NUM_SLITS; s++) begin : g_bank
    logic [COUNT_W-1:0] cnt [ROW_BINS];

    assign bank_rd[s] = cnt[row_bin];

    always_ff @(posedge clk) begin
      if (rst || (fire && advance)) begin
        for (int i = 0; i < ROW_BINS; i++) begin
          cnt[i] <= '0;
        end
      end else if (fire && (q_data.slit == SLIT_W'(s))) begin
        cnt[row_bin] <= new_count;
      end
    end
  end

  // Saturating increment and threshold test
  always_comb begin
    unique case (q_data.slit)
      2'd0:    cur_count = bank_rd[0];
      2'd1:    cur_count = bank_rd[1];
      2'd2:    cur_count = bank_rd[2];
      default: cur_count = '0;
    endcase
    new_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;
    flag      = (new_count >= cfg.hit_floor);
  end

  // Candidate: a flagged event is not displaced by an unflagged one
  assign take = hit && (!has_cand || flag || !best_flag);

  always_comb begin
    has_cand_next  = has_cand;
    best_slit_next = best_slit;
    best_row_next  = best_row;
    best_pol_next  = best_pol;
    best_flag_next = best_flag;
    if (take) begin
      has_cand_next  = 1'b1;
      best_slit_next = q_data.slit;
      best_row_next  = q_data.row;
      best_pol_next  = q_data.polarity;
      best_flag_next = flag;
    end
  end

  // Sample built from the candidate including this event
  always_comb begin
    if (has_cand_next) begin
      out_data.slit_index  = best_slit_next;
      out_data.row         = best_row_next;
      out_data.polarity    = best_pol_next;
      out_data.above_floor = best_flag_next;
    end else begin
      out_data.slit_index  = NO_SLIT;
      out_data.row         = '0;
      out_data.polarity    = 1'b0;
      out_data.above_floor = 1'b0;
    end
    out_data.weft = weft;
  end

  // Batch count wraps at 8 bits before the compare
  assign batch_tally_next = batch_tally + 1'b1;
  assign advance          = last_in_batch && (batch_tally_next >= cfg.batches);

  // Position, batch and weft state
  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      batch_tally <= '0;
      weft        <= '0;
    end else if (fire) begin
      if (last_in_batch) begin
        position <= '0;
        if (advance) begin
          batch_tally <= '0;
          weft        <= weft + 1'b1;
        end else begin
          batch_tally <= batch_tally_next;
        end
      end else begin
        position <= position + 1'b1;
      end
    end
  end

  // Candidate registers, cleared after each sample
  always_ff @(posedge clk) begin
    if (rst) begin
      has_cand  <= 1'b0;
      best_slit <= '0;
      best_row  <= '0;
      best_pol  <= 1'b0;
      best_flag <= 1'b0;
    end else if (fire) begin
      if (last_in_batch) begin
        has_cand  <= 1'b0;
        best_slit <= '0;
        best_row  <= '0;
        best_pol  <= 1'b0;
        best_flag <= 1'b0;
      end else begin
        has_cand  <= has_cand_next;
        best_slit <= best_slit_next;
        best_row  <= best_row_next;
        best_pol  <= best_pol_next;
        best_flag <= best_flag_next;
      end
    end
  end

endmodule

@@ rtl/event_slit_scan_sampler_core.sv @@
// Top level of the event slit scan sampler: register file, front, queues, back.
// Depends on ess_pkg, ess_fifo, ess_front and ess_back.
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------------------
//   events   | push / full        | column, row, polarity
//   samples  | pop / empty        | slit_index, sample_row, sample_polarity,
//            |                    | weft_column, above_floor
//   regs     | write_enable       | write_index, write_data
//
// One event per cycle sustained while the result queue has room; the back
// end's counter read-modify-write on flop banks sets that figure. An event
// reaches the middle queue on its transfer and is counted when the back end
// pops it; a sample can be popped the cycle after the last event of its batch
// is counted. A full result queue stalls the back end, then a full middle
// queue raises full. Reset clears counters and state, loads register defaults.
module event_slit_scan_sampler_core #(
  parameter int unsigned EVENTS_PER_BATCH = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [ess_pkg::COORD_W-1:0]    column,
  input  logic [ess_pkg::COORD_W-1:0]    row,
  input  logic                           polarity,
  output logic                           empty,
  input  logic                           pop,
  output logic [ess_pkg::SLIT_W-1:0]     slit_index,
  output logic [ess_pkg::COORD_W-1:0]    sample_row,
  output logic                           sample_polarity,
  output logic [ess_pkg::COORD_W-1:0]    weft_column,
  output logic                           above_floor,
  input  logic                           write_enable,
  input  logic [ess_pkg::CFG_IDX_W-1:0]  write_index,
  input  logic [ess_pkg::CFG_W-1:0]      write_data
);
  import ess_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 2;

  cfg_t    cfg;
  logic    mid_push;
  logic    mid_full;
  logic    mid_pop;
  logic    mid_empty;
  event_t  mid_in;
  event_t  mid_out;
  logic    res_push;
  logic    res_full;
  sample_t res_in;
  sample_t res_out;

  // Register file; writes to unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slit0_bin <= SLIT0_BIN_RST;
      cfg.slit1_bin <= SLIT1_BIN_RST;
      cfg.slit2_bin <= SLIT2_BIN_RST;
      cfg.hit_floor <= HIT_FLOOR_RST;
      cfg.batches   <= BATCHES_RST;
    end else if (write_enable) begin
      unique case (cfg_reg_e'(write_index))
        REG_SLIT0_BIN: cfg.slit0_bin <= write_data[BIN_W-1:0];
        REG_SLIT1_BIN: cfg.slit1_bin <= write_data[BIN_W-1:0];
        REG_SLIT2_BIN: cfg.slit2_bin <= write_data[BIN_W-1:0];
        REG_HIT_FLOOR: cfg.hit_floor <= write_data[COUNT_W-1:0];
        REG_BATCHES:   cfg.batches   <= write_data[COUNT_W-1:0];
        default:       ;
      endcase
    end
  end

  // Classification
  ess_front u_front (
    .push     (push),
    .full     (full),
    .column   (column),
    .row      (row),
    .polarity (polarity),
    .cfg      (cfg),
    .q_full   (mid_full),
    .q_push   (mid_push),
    .q_data   (mid_in)
  );

  // Queue between front and back
  ess_fifo #(
    .WIDTH ($bits(event_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk       (clk),
    .rst       (rst),
    .push      (mid_push),
    .push_data (mid_in),
    .full      (mid_full),
    .pop       (mid_pop),
    .pop_data  (mid_out),
    .empty     (mid_empty)
  );

  // Counting and sampling
  ess_back #(
    .EVENTS_PER_BATCH (EVENTS_PER_BATCH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (mid_empty),
    .q_data   (mid_out),
    .q_pop    (mid_pop),
    .out_full (res_full),
    .out_push (res_push),
    .out_data (res_in)
  );

  // Result queue
  ess_fifo #(
    .WIDTH ($bits(sample_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (res_out),
    .empty     (empty)
  );

  assign slit_index      = res_out.slit_index;
  assign sample_row      = res_out.row;
  assign sample_polarity = res_out.polarity;
  assign weft_column     = res_out.weft;
  assign above_floor     = res_out.above_floor;

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for event_slit_scan_sampler_core.
// Depends on ess_pkg and the sampler RTL; the expected samples are worked out in the bench.
module tb_top;
  import ess_pkg::*;

  localparam int unsigned EVENTS_PER_BATCH = 4;
  localparam int unsigned DRAIN_CYCLES     = 16;
  localparam int unsigned STALL_CYCLES     = 600;
  localparam int unsigned TIMEOUT_CYCLES   = 200000;
  localparam int unsigned MAX_REPORTS      = 10;
  localparam int unsigned PHASE_EVENTS     = 110;
  // Index past the register list; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // DUT connections
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic [COORD_W-1:0]   column = '0;
  logic [COORD_W-1:0]   row = '0;
  logic                 polarity = 1'b0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [SLIT_W-1:0]    slit_index;
  logic [COORD_W-1:0]   sample_row;
  logic                 sample_polarity;
  logic [COORD_W-1:0]   weft_column;
  logic                 above_floor;
  logic                 write_enable = 1'b0;
  logic [CFG_IDX_W-1:0] write_index = REG_SLIT0_BIN;
  logic [CFG_W-1:0]     write_data = '0;

  // Traffic shaping
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_pop = 1'b0;
  logic [BIN_W-1:0] aim_bins [NUM_SLITS];
  logic [4:0]       hot_row_bin = 5'd0;

  // Sampler model state
  cfg_t               model_cfg;
  logic [COUNT_W-1:0] hit_count [NUM_SLITS][ROW_BINS];
  logic [COORD_W-1:0] weft_now;
  logic [COUNT_W-1:0] batches_done;
  int unsigned        events_in_batch;
  logic               cand_valid;
  event_t             cand;
  logic               cand_above;
  sample_t            pending_samples [$];

  // Run statistics
  int unsigned fail_count = 0;
  int unsigned events_sent = 0;
  int unsigned samples_checked = 0;
  int unsigned weft_advances = 0;

  event_slit_scan_sampler_core #(
    .EVENTS_PER_BATCH(EVENTS_PER_BATCH)
  ) u_top (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .column(column), .row(row), .polarity(polarity),
    .empty(empty), .pop(pop),
    .slit_index(slit_index), .sample_row(sample_row),
    .sample_polarity(sample_polarity), .weft_column(weft_column),
    .above_floor(above_floor),
    .write_enable(write_enable), .write_index(write_index), .write_data(write_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sampler model
  // ---------------------------------------------------------------------------

  function automatic void clear_hit_counts();
    foreach (hit_count[i, j]) hit_count[i][j] = '0;
  endfunction

  function automatic void reset_sampler_model();
    model_cfg.slit0_bin = SLIT0_BIN_RST;
    model_cfg.slit1_bin = SLIT1_BIN_RST;
    model_cfg.slit2_bin = SLIT2_BIN_RST;
    model_cfg.hit_floor = HIT_FLOOR_RST;
    model_cfg.batches   = BATCHES_RST;
    clear_hit_counts();
    weft_now        = '0;
    batches_done    = '0;
    events_in_batch = 0;
    cand_valid      = 1'b0;
    cand            = '0;
    cand_above      = 1'b0;
  endfunction

  // Bin registers keep only their low bits; unknown indexes are dropped
  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
    case (idx)
      REG_SLIT0_BIN: model_cfg.slit0_bin = d[BIN_W-1:0];
      REG_SLIT1_BIN: model_cfg.slit1_bin = d[BIN_W-1:0];
      REG_SLIT2_BIN: model_cfg.slit2_bin = d[BIN_W-1:0];
      REG_HIT_FLOOR: model_cfg.hit_floor = d;
      REG_BATCHES:   model_cfg.batches   = d;
      default: ;
    endcase
  endfunction

  // Counts one event and, on the last event of a batch, queues the sample it ends with
  function automatic void predict_batch_sample(logic [COORD_W-1:0] c, logic [COORD_W-1:0] r,
                                               logic p);
    logic [BIN_W-1:0]  cbin;
    logic [SLIT_W-1:0] s;
    logic [4:0]        rbin;
    logic              flag;
    sample_t           smp;
    cbin = c[COORD_W-1:2];
    rbin = r[COORD_W-1:2];
    // lowest numbered slit wins on overlapping bins
    s = NO_SLIT;
    if (cbin == model_cfg.slit0_bin)      s = 2'd0;
    else if (cbin == model_cfg.slit1_bin) s = 2'd1;
    else if (cbin == model_cfg.slit2_bin) s = 2'd2;
    if (s != NO_SLIT) begin
      if (hit_count[s][rbin] != COUNT_MAX) hit_count[s][rbin] = hit_count[s][rbin] + 1'b1;
      flag = (hit_count[s][rbin] >= model_cfg.hit_floor);
      // a flagged candidate only gives way to another flagged event
      if (!cand_valid || flag >= cand_above) begin
        cand_valid   = 1'b1;
        cand.slit    = s;
        cand.row     = r;
        cand.polarity = p;
        cand_above   = flag;
      end
    end
    events_in_batch++;
    if (events_in_batch < EVENTS_PER_BATCH) return;
    events_in_batch = 0;

    if (cand_valid) begin
      smp.slit_index  = cand.slit;
      smp.row         = cand.row;
      smp.polarity    = cand.polarity;
      smp.above_floor = cand_above;
    end else begin
      smp.slit_index  = NO_SLIT;
      smp.row         = '0;
      smp.polarity    = 1'b0;
      smp.above_floor = 1'b0;
    end
    smp.weft = weft_now;
    pending_samples.push_back(smp);
    cand_valid = 1'b0;
    cand       = '0;
    cand_above = 1'b0;

    // weft step and flash clear
    batches_done = batches_done + 1'b1;
    if (batches_done >= model_cfg.batches) begin
      batches_done = '0;
      weft_now     = weft_now + 1'b1;
      clear_hit_counts();
      weft_advances++;
    end
  endfunction

  function automatic void log_mismatch(string what, sample_t want, sample_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%0t %s: expected slit %0d row %0d pol %0d weft %0d flag %0d",
               $realtime, what, want.slit_index, want.row, want.polarity, want.weft,
               want.above_floor);
      $display("    got slit %0d row %0d pol %0d weft %0d flag %0d",
               got.slit_index, got.row, got.polarity, got.weft, got.above_floor);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: register writes and event transfers feed the model, sample
  // transfers are checked against the oldest expected sample
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sample_t got;
    sample_t want;
    if (!rst) begin
      if (write_enable) apply_reg_write(write_index, write_data);
      if (push && !full) begin
        predict_batch_sample(column, row, polarity);
        events_sent++;
      end
      if (pop && !empty) begin
        got.slit_index  = slit_index;
        got.row         = sample_row;
        got.polarity    = sample_polarity;
        got.weft        = weft_column;
        got.above_floor = above_floor;
        if (pending_samples.size() == 0) begin
          log_mismatch("unexpected sample", '0, got);
        end else begin
          want = pending_samples.pop_front();
          samples_checked++;
          if (got.slit_index !== want.slit_index || got.row !== want.row ||
              got.polarity !== want.polarity || got.weft !== want.weft ||
              got.above_floor !== want.above_floor)
            log_mismatch("sample mismatch", want, got);
        end
      end
    end
  end

  // Receiver: random pop, forced low during a long hold-off
  always @(posedge clk) begin
    if (rst || hold_pop) pop <= 1'b0;
    else pop <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // push stays high after a transfer so back-to-back events need no gap
  task automatic send_event(input logic [COORD_W-1:0] c, input logic [COORD_W-1:0] r,
                            input logic p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    if (!push) push <= 1'b1;
    column   <= c;
    row      <= r;
    polarity <= p;
    do @(posedge clk); while (full);
  endtask

  // Mostly aimed at the watched bins and one busy row bin, the rest anywhere
  task automatic send_random_event();
    logic [COORD_W-1:0] c;
    logic [COORD_W-1:0] r;
    logic [1:0]         lo;
    int unsigned        pick;
    pick = $urandom_range(0, 9);
    lo   = 2'($urandom_range(0, 3));
    if (pick < 7) c = {aim_bins[pick % NUM_SLITS], lo};
    else c = 7'($urandom_range(0, 127));
    lo = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 9) < 6) r = {hot_row_bin, lo};
    else r = 7'($urandom_range(0, 127));
    send_event(c, r, 1'($urandom_range(0, 1)));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    write_enable <= 1'b1;
    write_index  <= idx;
    write_data   <= d;
    @(posedge clk);
    write_enable <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every expected sample, then let any partial batch finish counting
  task automatic settle();
    if (push) push <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  task automatic write_slit_bins(input logic [BIN_W-1:0] b0, input logic [BIN_W-1:0] b1,
                                 input logic [BIN_W-1:0] b2);
    write_reg(REG_SLIT0_BIN, {3'($urandom_range(0, 7)), b0});
    write_reg(REG_SLIT1_BIN, {3'($urandom_range(0, 7)), b1});
    write_reg(REG_SLIT2_BIN, {3'($urandom_range(0, 7)), b2});
    aim_bins[0] = b0;
    aim_bins[1] = b1;
    aim_bins[2] = b2;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: sentinel batch, last-wins, threshold crossing, flagged hold
  task automatic test_directed();
    // no slit hit, field extremes
    send_event(7'd0,   7'd0,   1'b0);
    send_event(7'd127, 7'd127, 1'b1);
    send_event(7'd4,   7'd64,  1'b1);
    send_event(7'd90,  7'd3,   1'b0);
    // every slit hit, slit 0 twice, last unflagged event wins
    send_event(7'd20,  7'd0,   1'b0);
    send_event(7'd60,  7'd127, 1'b1);
    send_event(7'd103, 7'd64,  1'b1);
    send_event(7'd23,  7'd1,   1'b0);
    // slit 1 top row bin crosses the threshold; later unflagged event loses
    send_event(7'd61,  7'd124, 1'b0);
    send_event(7'd62,  7'd125, 1'b1);
    send_event(7'd63,  7'd126, 1'b0);
    send_event(7'd20,  7'd2,   1'b1);
    // two flagged events, the later one wins
    send_event(7'd21,  7'd3,   1'b1);
    send_event(7'd100, 7'd127, 1'b0);
    send_event(7'd60,  7'd127, 1'b1);
    send_event(7'd0,   7'd5,   1'b0);
    settle();
  endtask

  // Overlapping bins, zero threshold, zero batch count, ignored index, maxima
  task automatic test_register_extremes();
    write_reg(REG_SLIT0_BIN, 8'hE0);
    write_reg(REG_SLIT1_BIN, 8'h20);
    write_reg(REG_SLIT2_BIN, 8'hC0);
    write_reg(REG_HIT_FLOOR, 8'h00);
    send_event(7'd0, 7'd9,  1'b1);
    send_event(7'd1, 7'd80, 1'b0);
    send_event(7'd2, 7'd44, 1'b1);
    send_event(7'd3, 7'd17, 1'b0);
    settle();
    write_reg(REG_SLIT0_BIN, 8'h1F);
    write_reg(REG_SLIT1_BIN, 8'hFF);
    write_reg(REG_SLIT2_BIN, 8'h3F);
    write_reg(REG_BATCHES,   8'h00);
    write_reg(REG_HIT_FLOOR, 8'd2);
    write_reg(REG_UNUSED,    8'hFF);
    send_event(7'd124, 7'd127, 1'b1);
    send_event(7'd127, 7'd126, 1'b0);
    send_event(7'd125, 7'd0,   1'b1);
    send_event(7'd126, 7'd64,  1'b1);
    send_event(7'd127, 7'd125, 1'b0);
    send_event(7'd124, 7'd124, 1'b1);
    send_event(7'd10,  7'd1,   1'b0);
    send_event(7'd126, 7'd127, 1'b0);
    settle();
  endtask

  // Top threshold and batch count, one cell driven well past saturation
  task automatic test_saturation();
    logic [1:0]         lo;
    logic [COORD_W-1:0] c;
    logic [COORD_W-1:0] r;
    write_slit_bins(5'd10, 5'd11, 5'd12);
    write_reg(REG_HIT_FLOOR, 8'hFF);
    write_reg(REG_BATCHES,   8'hFF);
    for (int i = 0; i < 320; i++) begin
      lo = 2'($urandom_range(0, 3));
      c  = {5'd10, lo};
      lo = 2'($urandom_range(0, 3));
      r  = {5'd7, lo};
      if ($urandom_range(0, 9) == 0) c = 7'($urandom_range(0, 127));
      send_event(c, r, 1'($urandom_range(0, 1)));
    end
    settle();
  endtask

  // Receiver holds off while the sender keeps offering events
  task automatic test_backpressure();
    write_slit_bins(5'd3, 5'd17, 5'd30);
    write_reg(REG_HIT_FLOOR, 8'd3);
    write_reg(REG_BATCHES,   8'd2);
    hot_row_bin = 5'd31;
    set_idling(0, 0);
    fork
      begin
        hold_pop <= 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
        hold_pop <= 1'b0;
      end
      begin
        for (int i = 0; i < 200; i++) send_random_event();
      end
    join
    settle();
  endtask

  // Random phases over three idling mixes; batch counts cover zero, the maximum
  // and a count lowered below the running batch counter
  task automatic test_random();
    logic [COUNT_W-1:0] phase_batches [6];
    logic [BIN_W-1:0]   b0;
    logic [BIN_W-1:0]   b1;
    logic [BIN_W-1:0]   b2;
    logic [COUNT_W-1:0] mh;
    phase_batches = '{8'd1, 8'd0, 8'd255, 8'd3, 8'd1, 8'd6};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) set_idling(63, 18);
      else if (ph == 4) set_idling(0, 0);
      settle();
      b0 = 5'($urandom_range(0, 31));
      b1 = ($urandom_range(0, 3) == 0) ? b0 : 5'($urandom_range(0, 31));
      b2 = 5'($urandom_range(0, 31));
      mh = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 6));
      write_slit_bins(b0, b1, b2);
      write_reg(REG_HIT_FLOOR, mh);
      write_reg(REG_BATCHES,   phase_batches[ph]);
      hot_row_bin = 5'($urandom_range(0, 31));
      for (int i = 0; i < PHASE_EVENTS; i++) send_random_event();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_sampler_model();
    aim_bins[0] = SLIT0_BIN_RST;
    aim_bins[1] = SLIT1_BIN_RST;
    aim_bins[2] = SLIT2_BIN_RST;
    set_idling(18, 63);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_register_extremes();
    test_saturation();
    test_backpressure();
    set_idling(18, 63);
    test_random();
    settle();

    if (pending_samples.size() != 0) begin
      fail_count++;
      $display("%0d expected samples never arrived", pending_samples.size());
    end
    $display("Covered %0d events and %0d checked samples across %0d weft steps.",
             events_sent, samples_checked, weft_advances);
    $display("Included: directed batches, register extremes, saturation,");
    $display("  long result stall, three idle mixes.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d failures", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("Run timed out");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
